FILE: rtl/sbst_pkg.sv
// Package for the segment/box slab test core: payload structs, fixed-point
// widths and constants. No dependencies.
package sbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_DIV     = 2 * NUM_AXES;
    localparam int DIFF_W      = COORD_WIDTH + 1;   // exact coordinate difference
    localparam int REM_W       = COORD_WIDTH + 2;   // divider remainder
    localparam int QUO_W       = FRAC_BITS + 1;     // one integer bit plus fraction
    localparam int NUM_STEPS   = FRAC_BITS + 1;     // one quotient bit per stage
    localparam int T_W         = FRAC_BITS + 3;     // signed parameter, holds +-2.0
    localparam int OUT_W       = FRAC_BITS + 1;

    localparam logic signed [T_W-1:0] T_ZERO = '0;
    localparam logic signed [T_W-1:0] T_ONE  = T_W'(1) << FRAC_BITS;
    localparam logic signed [T_W-1:0] T_SAT  = T_W'(2) << FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        t_coord box_min_x;
        t_coord box_min_y;
        t_coord box_min_z;
        t_coord box_max_x;
        t_coord box_max_y;
        t_coord box_max_z;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] t_enter;
    } t_out;

endpackage

FILE: rtl/segment_box_slab_test_core.sv
// Segment versus axis-aligned box slab test, fully pipelined.
// Depends on sbst_pkg for payload structs and widths.
//
// Takes one segment/box test per cycle and returns one result per test, in
// order. Coordinates are Q15.16. One stage forms the coordinate differences,
// FRAC_BITS + 1 stages run six restoring dividers side by side with one
// quotient bit each, and three stages apply signs, order and merge the slab
// intervals. The whole pipe advances together; it stalls only while the output
// register holds a result that has not been taken.
module segment_box_slab_test_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sbst_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sbst_pkg::t_out o_out_data
);

    localparam int W  = sbst_pkg::COORD_WIDTH;
    localparam int NS = sbst_pkg::NUM_STEPS;
    localparam int NA = sbst_pkg::NUM_AXES;
    localparam int ND = sbst_pkg::NUM_DIV;

    logic en;

    // divider pipe, index 0 is the setup stage
    logic                             r_vld  [0:NS];
    logic [sbst_pkg::REM_W-1:0]       r_rem  [0:NS][ND];
    logic [sbst_pkg::QUO_W-1:0]       r_q    [0:NS][ND];
    logic [sbst_pkg::DIFF_W-1:0]      r_den  [0:NS][NA];
    logic                             r_neg  [0:NS][ND];
    logic                             r_sat  [0:NS][ND];
    logic                             r_zero [0:NS][NA];
    logic                             r_zpass[0:NS][NA];

    // interval merge stages
    logic                             r_f1_vld, r_f2_vld;
    logic signed [sbst_pkg::T_W-1:0]  r_f1_lo[NA];
    logic signed [sbst_pkg::T_W-1:0]  r_f1_hi[NA];
    logic                             r_f1_pass, r_f2_pass;
    logic signed [sbst_pkg::T_W-1:0]  r_f2_lo_a, r_f2_lo_b, r_f2_hi_a, r_f2_hi_b;

    logic                             r_out_vld;
    sbst_pkg::t_out                   r_out;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // setup: differences, magnitudes, signs, saturation, zero-extent checks
    sbst_pkg::t_coord                 c_s[NA], c_e[NA], c_lo[NA], c_hi[NA];
    logic signed [W:0]                c_d[NA];
    logic signed [W:0]                c_n[ND];
    logic [W:0]                       c_ud[NA];
    logic [W:0]                       c_un[ND];
    logic                             c_neg[ND];
    logic                             c_sat[ND];
    logic                             c_zero[NA];
    logic                             c_zpass[NA];

    always_comb begin
        c_s[0]  = i_in_data.start_x;   c_s[1]  = i_in_data.start_y;
        c_s[2]  = i_in_data.start_z;
        c_e[0]  = i_in_data.end_x;     c_e[1]  = i_in_data.end_y;
        c_e[2]  = i_in_data.end_z;
        c_lo[0] = i_in_data.box_min_x; c_lo[1] = i_in_data.box_min_y;
        c_lo[2] = i_in_data.box_min_z;
        c_hi[0] = i_in_data.box_max_x; c_hi[1] = i_in_data.box_max_y;
        c_hi[2] = i_in_data.box_max_z;
        for (int a = 0; a < NA; a++) begin
            c_d[a]       = {c_e[a][W-1], c_e[a]} - {c_s[a][W-1], c_s[a]};
            c_n[2*a]     = {c_lo[a][W-1], c_lo[a]} - {c_s[a][W-1], c_s[a]};
            c_n[2*a+1]   = {c_hi[a][W-1], c_hi[a]} - {c_s[a][W-1], c_s[a]};
            c_ud[a]      = c_d[a][W] ? $unsigned(-c_d[a]) : $unsigned(c_d[a]);
            c_zero[a]    = (c_d[a] == '0);
            c_zpass[a]   = (c_s[a] >= c_lo[a]) && (c_s[a] <= c_hi[a]);
        end
        for (int j = 0; j < ND; j++) begin
            c_un[j]  = c_n[j][W] ? $unsigned(-c_n[j]) : $unsigned(c_n[j]);
            c_neg[j] = c_n[j][W] ^ c_d[j/2][W];
            c_sat[j] = {1'b0, c_un[j]} >= {c_ud[j/2], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NA; a++) begin
                r_den[0][a]   <= c_ud[a];
                r_zero[0][a]  <= c_zero[a];
                r_zpass[0][a] <= c_zpass[a];
            end
            for (int j = 0; j < ND; j++) begin
                r_rem[0][j] <= {1'b0, c_un[j]};
                r_q[0][j]   <= '0;
                r_neg[0][j] <= c_neg[j];
                r_sat[0][j] <= c_sat[j];
            end
        end
    end

    // restoring division, one quotient bit per stage; first stage has no shift
    for (genvar k = 1; k <= NS; k++) begin : g_div
        logic [sbst_pkg::REM_W-1:0] c_r[ND];
        logic                       c_ge[ND];

        always_comb begin
            for (int j = 0; j < ND; j++) begin
                c_r[j]  = (k == 1) ? r_rem[k-1][j] : (r_rem[k-1][j] << 1);
                c_ge[j] = c_r[j] >= {1'b0, r_den[k-1][j/2]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int a = 0; a < NA; a++) begin
                    r_den[k][a]   <= r_den[k-1][a];
                    r_zero[k][a]  <= r_zero[k-1][a];
                    r_zpass[k][a] <= r_zpass[k-1][a];
                end
                for (int j = 0; j < ND; j++) begin
                    r_rem[k][j] <= c_ge[j] ? (c_r[j] - {1'b0, r_den[k-1][j/2]}) : c_r[j];
                    r_q[k][j]   <= {r_q[k-1][j][sbst_pkg::QUO_W-2:0], c_ge[j]};
                    r_neg[k][j] <= r_neg[k-1][j];
                    r_sat[k][j] <= r_sat[k-1][j];
                end
            end
        end
    end

    // sign, saturation and ordering of each axis's entry/exit pair
    logic signed [sbst_pkg::T_W-1:0] c_mag[ND], c_t[ND];
    logic signed [sbst_pkg::T_W-1:0] c_lo_t[NA], c_hi_t[NA];
    logic                            c_pass;

    always_comb begin
        c_pass = 1'b1;
        for (int j = 0; j < ND; j++) begin
            c_mag[j] = r_sat[NS][j] ? sbst_pkg::T_SAT
                                    : $signed({2'b00, r_q[NS][j]});
            c_t[j]   = r_neg[NS][j] ? -c_mag[j] : c_mag[j];
        end
        for (int a = 0; a < NA; a++) begin
            if (r_zero[NS][a]) begin
                c_lo_t[a] = sbst_pkg::T_ZERO;
                c_hi_t[a] = sbst_pkg::T_ONE;
                c_pass    = c_pass && r_zpass[NS][a];
            end else if (c_t[2*a] > c_t[2*a+1]) begin
                c_lo_t[a] = c_t[2*a+1];
                c_hi_t[a] = c_t[2*a];
            end else begin
                c_lo_t[a] = c_t[2*a];
                c_hi_t[a] = c_t[2*a+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_f1_vld  <= r_vld[NS];
            r_f2_vld  <= r_f1_vld;
            r_out_vld <= r_f2_vld;
        end
    end

    // interval merge: first level of max/min trees
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NA; a++) begin
                r_f1_lo[a] <= c_lo_t[a];
                r_f1_hi[a] <= c_hi_t[a];
            end
            r_f1_pass <= c_pass;
            r_f2_pass <= r_f1_pass;
            r_f2_lo_a <= (r_f1_lo[0] > r_f1_lo[1]) ? r_f1_lo[0] : r_f1_lo[1];
            r_f2_lo_b <= (r_f1_lo[2] > sbst_pkg::T_ZERO) ? r_f1_lo[2] : sbst_pkg::T_ZERO;
            r_f2_hi_a <= (r_f1_hi[0] < r_f1_hi[1]) ? r_f1_hi[0] : r_f1_hi[1];
            r_f2_hi_b <= (r_f1_hi[2] < sbst_pkg::T_ONE) ? r_f1_hi[2] : sbst_pkg::T_ONE;
        end
    end

    // final merge and hit decision into the output register
    logic signed [sbst_pkg::T_W-1:0] c_tmin, c_tmax;
    logic                            c_ok;

    always_comb begin
        c_tmin = (r_f2_lo_a > r_f2_lo_b) ? r_f2_lo_a : r_f2_lo_b;
        c_tmax = (r_f2_hi_a < r_f2_hi_b) ? r_f2_hi_a : r_f2_hi_b;
        c_ok   = r_f2_pass && (c_tmin <= c_tmax);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit     <= c_ok;
            r_out.t_enter <= c_ok ? c_tmin[sbst_pkg::OUT_W-1:0] : '0;
        end
    end

    // a miss always reports a zero entry parameter
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.t_enter == '0))
        else $error("miss with nonzero t_enter");

    // entry parameter never exceeds 1.0
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({2'b00, o_out_data.t_enter} <= sbst_pkg::T_ONE))
        else $error("t_enter above 1.0");

    // ordered pair per axis after the sign stage
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_vld |-> ((r_f1_lo[0] <= r_f1_hi[0]) && (r_f1_lo[1] <= r_f1_hi[1])
                      && (r_f1_lo[2] <= r_f1_hi[2])))
        else $error("slab bounds out of order");

    // a stalled pipe keeps its second merge-stage valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_f2_vld))
        else $error("pipe moved during stall");

endmodule
